>>> hdl/pba_pkg.sv
// Shared types, codes and mask helpers for the page bitmap allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pba_pkg;

	// bitmap word geometry
	localparam int WORD_W    = 64;
	localparam int WORD_LG   = 6;
	localparam int LVL_N     = WORD_LG + 1;

	// field and position widths fixed by the request and response formats
	localparam int IDX_W     = 12;
	localparam int CNT_W     = 13;
	localparam int POS_W     = 14;
	localparam int WN_W      = POS_W - WORD_LG;
	localparam int RUN_W     = 14;
	localparam int ADDR_W    = 64;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 1;

	// pages beyond this can never be reached with a 13-bit limit
	localparam int MAX_TRACK = 8192;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 13'd4096;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2,
		ST_ZERO     = 2'd3
	} status_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGE_LIMIT  = 1'b0,
		CFG_HHDM_OFFSET = 1'b1
	} cfg_reg_e;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_RESULT
	} state_e;

	// request and response beats
	typedef struct packed {
		logic [1:0]       operation;
		logic [IDX_W-1:0] page_index;
		logic [CNT_W-1:0] page_count;
		logic             map_high;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  found_index;
		logic [ADDR_W-1:0] address;
	} rsp_t;

	// sequencer to scan unit
	typedef struct packed {
		logic             start;
		logic             valid;
		logic             last;
		logic [WN_W-1:0]  wn;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] lim;
	} scan_req_t;

	// scan unit to sequencer
	typedef struct packed {
		logic            valid;
		logic            last;
		logic [WN_W-1:0] wn;
		word_t           hits;
	} scan_res_t;

	typedef struct packed {
		logic            en;
		logic [WN_W-1:0] addr;
		word_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic            en;
		logic [WN_W-1:0] addr;
	} mem_rd_t;

	// finished request, before the address add
	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] found;
		logic             add_offset;
	} result_t;

	// bits at or above t; none when t reaches the word width
	function automatic word_t ge_mask(input logic [WORD_LG:0] t);
		word_t m;
		m = '1;
		return t[WORD_LG] ? '0 : (m << t[WORD_LG-1:0]);
	endfunction

	// bits lo..hi inclusive
	function automatic word_t span_mask(input logic [WORD_LG-1:0] lo,
			input logic [WORD_LG-1:0] hi);
		word_t m;
		m = '1;
		return (m << lo) & (m >> (~hi));
	endfunction

endpackage

`default_nettype wire

>>> hdl/pba_bitmap_mem.sv
// Used-bit storage: one 64-bit word of page bits per entry.
// One write port and one read port with registered read data; uses pba_pkg.
`default_nettype none

module pba_bitmap_mem #(
	parameter int WORDS = 64
) (
	input  logic             clk,
	input  pba_pkg::mem_wr_t wr,
	input  pba_pkg::mem_rd_t rd,
	output pba_pkg::word_t   rdata
);
	import pba_pkg::*;

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

	word_t mem [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr[AW-1:0]];
		end
	end

endmodule

`default_nettype wire

>>> hdl/pba_word_scan.sv
// Word scan unit: finds every bit position of one bitmap word at which a free
// run of the requested length ends, carrying the free tail across words. Uses pba_pkg.
`default_nettype none

module pba_word_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  pba_pkg::scan_req_t req,
	input  pba_pkg::word_t     rdata,
	output pba_pkg::scan_res_t res
);
	import pba_pkg::*;

	localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(MAX_TRACK);

	word_t                lvl [LVL_N];
	word_t                used_pre;
	word_t                free_pre;
	word_t                win;
	word_t                t1;
	word_t                t2;
	word_t                lmask;
	word_t                hits;
	logic [2:0]           mexp;
	logic [WORD_LG:0]     d7;
	logic                 small_run;
	logic [WORD_LG-1:0]   hi_used;
	logic                 any_used;
	logic [RUN_W:0]       run_sum;
	logic [RUN_W:0]       need;
	logic [RUN_W-1:0]     run_next;
	logic [POS_W-1:0]     base;
	logic [POS_W-1:0]     rem;

	logic [RUN_W-1:0]     run_q;
	logic                 res_v_s1;
	logic                 last_s1;
	logic [WN_W-1:0]      wn_s1;
	word_t                hits_s1;

	always_comb begin
		// free windows of length 1, 2, 4 .. 64 ending at each bit
		lvl[0] = ~rdata;
		for (int i = 1; i < LVL_N; i++) begin
			lvl[i] = lvl[i-1] & (lvl[i-1] << (1 << (i - 1)));
		end

		// a window of length k is two overlapping power-of-two windows
		mexp = '0;
		for (int i = 0; i < LVL_N; i++) begin
			if (req.cnt[i]) begin
				mexp = 3'(i);
			end
		end
		small_run = (req.cnt <= CNT_W'(WORD_W));
		d7 = req.cnt[WORD_LG:0] - ((WORD_LG+1)'(1) << mexp);
		win = lvl[mexp] & (lvl[mexp] << d7[WORD_LG-1:0]);
		t1 = small_run ? ge_mask(req.cnt[WORD_LG:0] - (WORD_LG+1)'(1)) : '0;

		// prefix of free bits from bit 0
		used_pre = rdata;
		for (int i = 0; i < WORD_LG; i++) begin
			used_pre = used_pre | (used_pre << (1 << i));
		end
		free_pre = ~used_pre;

		// runs continuing from earlier words
		need = {2'b0, req.cnt} - {1'b0, run_q} - (RUN_W+1)'(1);
		if (need[RUN_W]) begin
			t2 = '1;
		end else if (need[RUN_W-1:WORD_LG] != '0) begin
			t2 = '0;
		end else begin
			t2 = ge_mask({1'b0, need[WORD_LG-1:0]});
		end

		// pages at or beyond the limit are not searchable
		base = {req.wn, {WORD_LG{1'b0}}};
		rem = {1'b0, req.lim} - base;
		if (rem[POS_W-1:WORD_LG] != '0) begin
			lmask = '1;
		end else begin
			lmask = ~ge_mask({1'b0, rem[WORD_LG-1:0]});
		end

		hits = ((win & t1) | (free_pre & t2)) & lmask;

		// free tail of this word for the next one
		any_used = |rdata;
		hi_used = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (rdata[i]) begin
				hi_used = WORD_LG'(i);
			end
		end
		run_sum = {1'b0, run_q} + (RUN_W+1)'(WORD_W);
		if (!any_used) begin
			run_next = (run_sum > {1'b0, RUN_CAP}) ? RUN_CAP : run_sum[RUN_W-1:0];
		end else begin
			run_next = {{(RUN_W-WORD_LG){1'b0}}, ~hi_used};
		end
	end

	// carried run and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			res_v_s1 <= 1'b0;
		end else begin
			res_v_s1 <= req.valid;
			if (req.start) begin
				run_q <= '0;
			end else if (req.valid) begin
				run_q <= run_next;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (req.valid) begin
			last_s1 <= req.last;
			wn_s1 <= req.wn;
			hits_s1 <= hits;
		end
	end

	assign res = '{valid: res_v_s1, last: last_s1, wn: wn_s1, hits: hits_s1};

endmodule

`default_nettype wire

>>> hdl/pba_ctrl.sv
// Sequencer: clearing pass, request decode, word-by-word scan, read-modify-write
// of the run, and result hand-off. Uses pba_pkg.
`default_nettype none

module pba_ctrl #(
	parameter int TRACK = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  pba_pkg::req_t             req,
	input  logic [pba_pkg::CNT_W-1:0] page_limit,
	output pba_pkg::mem_rd_t          rd,
	output pba_pkg::mem_wr_t          wr,
	input  pba_pkg::word_t            rdata,
	output pba_pkg::scan_req_t        scan_req,
	input  pba_pkg::scan_res_t        scan_res,
	output logic                      res_valid,
	input  logic                      res_ready,
	output pba_pkg::result_t          result
);
	import pba_pkg::*;

	localparam int WORDS = (TRACK + WORD_W - 1) / WORD_W;

	state_e             state_q, state_d;
	logic [POS_W-1:0]   a_q, a_d;
	logic [POS_W-1:0]   end_q, end_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [CNT_W-1:0]   lim_q, lim_d;
	logic               set_q, set_d;
	logic [1:0]         status_q, status_d;
	logic               alloc_ok_q, alloc_ok_d;
	logic               map_q, map_d;
	logic [WN_W-1:0]    issue_q, issue_d;
	logic [WN_W-1:0]    clr_q, clr_d;
	logic               rd_v_s1;
	logic [WN_W-1:0]    rd_wn_s1;

	logic [CNT_W-1:0]   lim_eff;
	logic [POS_W-1:0]   run_end;
	logic [POS_W-1:0]   found;
	logic [WORD_LG-1:0] hit_pos;
	logic               hit_now;
	logic               scan_start;
	logic [WORD_LG-1:0] lo;
	logic [WORD_LG-1:0] hi;
	word_t              mask;
	word_t              merged;

	// effective limit and run bounds
	always_comb begin
		lim_eff = ({1'b0, page_limit} > POS_W'(TRACK)) ? CNT_W'(TRACK) : page_limit;
		run_end = {2'b0, req.page_index} + {1'b0, req.page_count};
	end

	// first hit of the scanned word
	always_comb begin
		hit_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (scan_res.hits[i]) begin
				hit_pos = WORD_LG'(i);
			end
		end
		hit_now = (state_q == S_SCAN) && scan_res.valid && (|scan_res.hits);
		found = {scan_res.wn, hit_pos} + POS_W'(1) - {1'b0, cnt_q};
	end

	// merge of the run into the word just read
	always_comb begin
		lo = (rd_wn_s1 == a_q[POS_W-1:WORD_LG]) ? a_q[WORD_LG-1:0] : '0;
		hi = (rd_wn_s1 == end_q[POS_W-1:WORD_LG]) ? end_q[WORD_LG-1:0] : '1;
		mask = span_mask(lo, hi);
		merged = set_q ? (rdata | mask) : (rdata & ~mask);
	end

	// state register and request context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			issue_q <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			issue_q <= issue_d;
			rd_v_s1 <= rd.en;
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;
		end_q <= end_d;
		cnt_q <= cnt_d;
		lim_q <= lim_d;
		set_q <= set_d;
		status_q <= status_d;
		alloc_ok_q <= alloc_ok_d;
		map_q <= map_d;
		rd_wn_s1 <= rd.addr;
	end

	// next state and outputs
	always_comb begin
		state_d = state_q;
		a_d = a_q;
		end_d = end_q;
		cnt_d = cnt_q;
		lim_d = lim_q;
		set_d = set_q;
		status_d = status_q;
		alloc_ok_d = alloc_ok_q;
		map_d = map_q;
		issue_d = issue_q;
		clr_d = clr_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		scan_start = 1'b0;
		rd = '{en: 1'b0, addr: issue_q};
		wr = '{en: 1'b0, addr: rd_wn_s1, data: merged};

		unique case (state_q)
			S_CLEAR: begin
				// every page starts out used
				wr = '{en: 1'b1, addr: clr_q, data: '1};
				clr_d = clr_q + WN_W'(1);
				if (clr_q == WN_W'(WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					scan_start = 1'b1;
					cnt_d = req.page_count;
					lim_d = lim_eff;
					map_d = req.map_high;
					alloc_ok_d = 1'b0;
					a_d = {2'b0, req.page_index};
					set_d = (req.operation == OP_RESERVE);
					state_d = S_RESULT;
					priority if (req.operation != OP_ALLOC && req.operation != OP_FREE &&
							req.operation != OP_RESERVE) begin
						status_d = ST_RANGE;
					end else if (req.page_count == '0) begin
						status_d = ST_ZERO;
					end else if (req.operation == OP_ALLOC) begin
						if (req.page_count > lim_eff) begin
							status_d = ST_NO_SPACE;
						end else begin
							end_d = {1'b0, lim_eff} - POS_W'(1);
							issue_d = '0;
							state_d = S_SCAN;
						end
					end else if (run_end > {1'b0, lim_eff}) begin
						status_d = ST_RANGE;
					end else begin
						status_d = ST_OK;
						end_d = run_end - POS_W'(1);
						issue_d = {2'b0, req.page_index[IDX_W-1:WORD_LG]};
						state_d = S_MARK;
					end
				end
			end
			S_SCAN: begin
				if (hit_now) begin
					a_d = found;
					end_d = {scan_res.wn, hit_pos};
					issue_d = found[POS_W-1:WORD_LG];
					set_d = 1'b1;
					alloc_ok_d = 1'b1;
					status_d = ST_OK;
					state_d = S_MARK;
				end else begin
					// one word read per cycle up to the limit
					if (issue_q <= end_q[POS_W-1:WORD_LG]) begin
						rd.en = 1'b1;
						issue_d = issue_q + WN_W'(1);
					end
					if (scan_res.valid && scan_res.last) begin
						status_d = ST_NO_SPACE;
						state_d = S_RESULT;
					end
				end
			end
			S_MARK: begin
				// read word, write it back merged on the next cycle
				if (issue_q <= end_q[POS_W-1:WORD_LG]) begin
					rd.en = 1'b1;
					issue_d = issue_q + WN_W'(1);
				end
				if (rd_v_s1) begin
					wr.en = 1'b1;
					if (rd_wn_s1 == end_q[POS_W-1:WORD_LG]) begin
						state_d = S_RESULT;
					end
				end
			end
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign scan_req = '{
		start: scan_start,
		valid: rd_v_s1 && (state_q == S_SCAN),
		last: (rd_wn_s1 == end_q[POS_W-1:WORD_LG]),
		wn: rd_wn_s1,
		cnt: cnt_q,
		lim: lim_q
	};

	assign result = '{
		status: status_q,
		found: alloc_ok_q ? a_q[CNT_W-1:0] : '0,
		add_offset: alloc_ok_q && map_q
	};

endmodule

`default_nettype wire

>>> hdl/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: configuration registers, response
// register and address add. Depends on pba_pkg, pba_bitmap_mem, pba_word_scan, pba_ctrl.
//
// One used bit per page, held as 64-bit words in a single-port-read memory.
// After reset a clearing pass writes every word to all-used, ceil(min(PAGES, 8192) / 64)
// words (64 at the default size), with req_ready low.
// An allocate reads one word per cycle from page 0 upward, at most ceil(limit / 64)
// words, and stops at the word where the first fitting run ends. Free and reserve
// read and rewrite each word the run covers, and a rejected request goes straight
// to the response. The rate is set by the one memory read per cycle, shared by the
// scan and the read-modify-write of the run. One request is worked on at a time; a
// finished response waits in its own register, so the next request is taken while
// it is still unclaimed.
`default_nettype none

module page_bitmap_allocator #(
	parameter int PAGES      = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  pba_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output pba_pkg::rsp_t                 rsp,
	input  logic                          cfg_write_en,
	input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pba_pkg::CFG_W-1:0]     cfg_data
);
	import pba_pkg::*;

	localparam int TRACK = (PAGES < MAX_TRACK) ? PAGES : MAX_TRACK;
	localparam int WORDS = (TRACK + WORD_W - 1) / WORD_W;

	logic [CNT_W-1:0]  page_limit_q;
	logic [ADDR_W-1:0] hhdm_offset_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	mem_rd_t           rd;
	mem_wr_t           wr;
	word_t             rdata;
	scan_req_t         scan_req;
	scan_res_t         scan_res;
	logic              res_valid;
	logic              res_ready;
	result_t           result;
	logic [ADDR_W-1:0] address;

	pba_bitmap_mem #(
		.WORDS(WORDS)
	) u_mem (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.rdata(rdata)
	);

	pba_word_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (scan_req),
		.rdata (rdata),
		.res   (scan_res)
	);

	pba_ctrl #(
		.TRACK(TRACK)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.page_limit(page_limit_q),
		.rd        (rd),
		.wr        (wr),
		.rdata     (rdata),
		.scan_req  (scan_req),
		.scan_res  (scan_res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= LIMIT_RESET;
			hhdm_offset_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_PAGE_LIMIT:  page_limit_q <= cfg_data[CNT_W-1:0];
				CFG_HHDM_OFFSET: hhdm_offset_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// page address, plus the high mapping offset when asked
	assign address = (ADDR_W'(result.found) << PAGE_SHIFT) +
		(result.add_offset ? hhdm_offset_q : '0);

	// response register
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= '{
				status: result.status,
				found_index: result.found[IDX_W-1:0],
				address: address
			};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> tb/pba_checker.sv
// Checker for the page bitmap allocator: follows the configuration writes,
// keeps its own copy of the page bitmap and compares every response beat.
// Depends on pba_pkg.

module pba_checker
	import pba_pkg::*;
#(
	parameter int PAGES      = 4096,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rsp_t                 rsp,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   responses_due,
	output int                   mismatches
);

	// shadow of the block state
	bit               page_used [PAGES];
	logic [CNT_W-1:0] limit_reg;
	logic [ADDR_W-1:0] offset_reg;
	rsp_t             due_responses [$];
	rsp_t             oldest;

	task automatic report(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// applies one request to the shadow bitmap and returns its response
	function automatic rsp_t apply_request(input req_t r);
		rsp_t o;
		int   lim;
		int   run;
		int   first;
		bit   hit;
		o     = '0;
		run   = 0;
		first = 0;
		hit   = 1'b0;
		lim   = (int'(limit_reg) > PAGES) ? PAGES : int'(limit_reg);
		o.status = ST_OK;
		case (r.operation)
			OP_ALLOC: begin
				if (r.page_count == '0) begin
					o.status = ST_ZERO;
				end else begin
					o.status = ST_NO_SPACE;
					// first fit: lowest run of free pages ending below the limit
					if (int'(r.page_count) <= lim) begin
						for (int i = 0; i < lim && !hit; i++) begin
							if (page_used[i]) begin
								run = 0;
							end else begin
								run++;
								if (run == int'(r.page_count)) begin
									first = i + 1 - run;
									hit   = 1'b1;
								end
							end
						end
					end
					if (hit) begin
						for (int k = 0; k < int'(r.page_count); k++)
							page_used[first + k] = 1'b1;
						o.status      = ST_OK;
						o.found_index = first[IDX_W-1:0];
						o.address     = (64'(first) << PAGE_SHIFT)
							+ (r.map_high ? offset_reg : 64'd0);
					end
				end
			end
			OP_FREE, OP_RESERVE: begin
				if (r.page_count == '0) begin
					o.status = ST_ZERO;
				end else if (int'(r.page_index) + int'(r.page_count) > lim) begin
					o.status = ST_RANGE;
				end else begin
					for (int k = 0; k < int'(r.page_count); k++)
						page_used[int'(r.page_index) + k] = (r.operation == OP_RESERVE);
				end
			end
			// unused operation code
			default: o.status = ST_RANGE;
		endcase
		return o;
	endfunction

	// watch config writes, response beats and request beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (page_used[p])
				page_used[p] = 1'b1;
			limit_reg  = LIMIT_RESET;
			offset_reg = '0;
			due_responses.delete();
			mismatches = 0;
			responses_due <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_PAGE_LIMIT:  limit_reg  = cfg_data[CNT_W-1:0];
					CFG_HHDM_OFFSET: offset_reg = cfg_data;
					default: ;
				endcase
			end
			// responses belong to earlier requests, so compare before queuing
			if (rsp_valid && rsp_ready) begin
				if (due_responses.size() == 0) begin
					report("response beat with nothing due", 64'(rsp.status), 64'd0);
				end else begin
					oldest = due_responses.pop_front();
					if (rsp.status !== oldest.status)
						report("status", 64'(rsp.status), 64'(oldest.status));
					if (rsp.found_index !== oldest.found_index)
						report("found_index", 64'(rsp.found_index), 64'(oldest.found_index));
					if (rsp.address !== oldest.address)
						report("address", rsp.address, oldest.address);
				end
			end
			if (req_valid && req_ready)
				due_responses.push_back(apply_request(req));
			responses_due <= due_responses.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Testbench top for the page bitmap allocator: clock, reset, configuration
// phases, request stimulus, response stalls, watchdog and verdict.
// Depends on pba_pkg, page_bitmap_allocator and pba_checker.

module tb_top;
	import pba_pkg::*;

	localparam int PAGES        = 4096;
	localparam int PAGE_SHIFT   = 12;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 128;
	localparam int PHASES       = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 req_valid    = 1'b0;
	logic                 req_ready;
	req_t                 req          = '0;
	logic                 rsp_valid;
	logic                 rsp_ready    = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_PAGE_LIMIT;
	logic [CFG_W-1:0]     cfg_data     = '0;

	int responses_due;
	int mismatches;
	int burst_left  = 0;
	int cur_limit   = PAGES;
	int idle_cycles = 0;
	int rx_tick     = 0;
	int rx_mode     = 0;
	int stall_left  = 0;

	logic [CNT_W-1:0] phase_limit [PHASES] = '{13'd4096, 13'd1, 13'd0, 13'd8191,
		13'd200, 13'd4095, 13'd64, 13'd777};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	page_bitmap_allocator #(
		.PAGES(PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pba_checker #(
		.PAGES(PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) alloc_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.responses_due(responses_due),
		.mismatches(mismatches)
	);

	// response stalls: always ready, coin flip, random stall bursts or a fixed pattern, the mode drawn at random
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 256 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			2: begin
				if (stall_left > 0) begin
					stall_left--;
					rsp_ready <= 1'b0;
				end else begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(1, 24);
				end
			end
			default: rsp_ready <= (rx_tick % 3 == 0);
		endcase
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_write_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [1:0] op, input int idx, input int cnt,
			input bit high);
		req_t r;
		r.operation  = op;
		r.page_index = idx[IDX_W-1:0];
		r.page_count = cnt[CNT_W-1:0];
		r.map_high   = high;
		return r;
	endfunction

	// mostly runs that fit the current limit, some noise and rejects
	function automatic req_t random_item();
		req_t r;
		int   roll;
		int   cnt;
		r.operation  = OP_ALLOC;
		r.page_index = IDX_W'($urandom);
		r.page_count = CNT_W'($urandom);
		r.map_high   = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			r.operation = OP_UNUSED;
		end else if (roll < 12 || cur_limit == 0) begin
			r.operation = 2'($urandom_range(0, 2));
			if (roll < 8)
				r.page_count = '0;
		end else if (roll < 14) begin
			// release everything to reopen space
			r.operation  = OP_FREE;
			r.page_index = '0;
			r.page_count = CNT_W'(cur_limit);
		end else begin
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 16);
			if (cnt > cur_limit)
				cnt = cur_limit;
			r.page_count = CNT_W'(cnt);
			if (roll < 52) begin
				r.operation = OP_ALLOC;
			end else begin
				r.operation  = (roll < 86) ? OP_FREE : OP_RESERVE;
				r.page_index = IDX_W'($urandom_range(0, cur_limit - cnt));
				// run ending one page past the limit
				if ($urandom_range(0, 19) == 0)
					r.page_index = IDX_W'(cur_limit - cnt + 1);
			end
		end
		return r;
	endfunction

	// one request beat, sent in bursts with random gaps
	task automatic send_req(input req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
		end
		req       <= r;
		req_valid <= 1'b1;
		burst_left--;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (responses_due != 0);
	endtask

	// both registers, written back to back while the block is idle
	task automatic write_regs(input logic [CNT_W-1:0] limit, input logic [ADDR_W-1:0] offset);
		wait_drained();
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_PAGE_LIMIT;
		cfg_data     <= CFG_W'(limit);
		@(posedge clk);
		cfg_index    <= CFG_HHDM_OFFSET;
		cfg_data     <= offset;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_limit = (int'(limit) > PAGES) ? PAGES : int'(limit);
	endtask

	initial begin
		logic [ADDR_W-1:0] offset;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_regs(13'd4096, 64'hFFFF_8000_0000_0000);

		// directed: everything starts used, then whole-range and edge runs
		send_req(make_req(OP_ALLOC, 0, 1, 1'b0));
		send_req(make_req(OP_FREE, 0, 4096, 1'b0));
		send_req(make_req(OP_ALLOC, 0, 4096, 1'b1));
		send_req(make_req(OP_FREE, 4095, 1, 1'b0));
		send_req(make_req(OP_ALLOC, 0, 1, 1'b1));
		send_req(make_req(OP_FREE, 4095, 2, 1'b0));
		send_req(make_req(OP_RESERVE, 0, 0, 1'b0));
		send_req(make_req(OP_ALLOC, 0, 0, 1'b1));
		send_req(make_req(OP_FREE, 5, 0, 1'b0));
		send_req(make_req(OP_UNUSED, 4095, 8191, 1'b1));
		send_req(make_req(OP_ALLOC, 4095, 8191, 1'b1));
		send_req(make_req(OP_ALLOC, 0, 4097, 1'b0));
		send_req(make_req(OP_FREE, 100, 50, 1'b0));
		send_req(make_req(OP_RESERVE, 120, 5, 1'b0));
		send_req(make_req(OP_ALLOC, 0, 50, 1'b0));
		send_req(make_req(OP_ALLOC, 0, 20, 1'b1));
		send_req(make_req(OP_ALLOC, 0, 20, 1'b0));
		send_req(make_req(OP_ALLOC, 0, 6, 1'b1));
		send_req(make_req(OP_ALLOC, 0, 5, 1'b1));
		send_req(make_req(OP_FREE, 10, 5, 1'b0));
		send_req(make_req(OP_FREE, 10, 5, 1'b0));
		send_req(make_req(OP_RESERVE, 10, 5, 1'b0));
		send_req(make_req(OP_RESERVE, 10, 5, 1'b0));
		send_req(make_req(OP_FREE, 4095, 8191, 1'b0));

		// random phases over several register settings
		for (int p = 0; p < PHASES; p++) begin
			offset = (p == 0) ? 64'd0 : (p == 1) ? '1 : {$urandom, $urandom};
			write_regs(phase_limit[p], offset);
			repeat (PHASE_ITEMS) send_req(random_item());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
hdl/pba_pkg.sv
hdl/pba_bitmap_mem.sv
hdl/pba_word_scan.sv
hdl/pba_ctrl.sv
hdl/page_bitmap_allocator.sv
tb/pba_checker.sv
tb/tb_top.sv
